### hw/rtl/mhku_pkg.sv
// shared types and constants for the min-heap key update block
`default_nettype none

package mhku_pkg;

   localparam int IDX_W = 10;
   localparam int KEY_W = 32;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_DEC  = 2'd1,
      CMD_INC  = 2'd2,
      CMD_READ = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK          = 2'd0,
      STS_NOT_SMALLER = 2'd1,
      STS_NOT_LARGER  = 2'd2,
      STS_RANGE       = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_UP_READ,
      S_UP_CMP,
      S_DN_READ,
      S_DN_CMP,
      S_FINISH
   } state_type;

   typedef struct packed {
      status_type               status;
      logic signed [KEY_W-1:0]  read_key;
      logic [IDX_W-1:0]         final_index;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/mhku_store.sv
// heap key memory: one write port, two registered read ports
`default_nettype none

module mhku_store #(
   parameter int HEAP_DEPTH = 1024,
   localparam int AddrW = $clog2(HEAP_DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [AddrW-1:0]              wr_addr,
   input  wire logic [mhku_pkg::KEY_W-1:0]    wr_data,
   input  wire logic [AddrW-1:0]              rd_a_addr,
   input  wire logic [AddrW-1:0]              rd_b_addr,
   output logic      [mhku_pkg::KEY_W-1:0]    rd_a_data,
   output logic      [mhku_pkg::KEY_W-1:0]    rd_b_data
);
   import mhku_pkg::*;

   logic [KEY_W-1:0] heap_mem [HEAP_DEPTH];
   logic [KEY_W-1:0] rd_a_data_ff;
   logic [KEY_W-1:0] rd_b_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_data_ff <= heap_mem[rd_a_addr];
      rd_b_data_ff <= heap_mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

`default_nettype wire

### hw/rtl/mhku_ctrl.sv
// command sequencer: range check, load, read, key compare and sift up or down through the store
`default_nettype none

module mhku_ctrl #(
   parameter int HEAP_DEPTH = 1024,
   localparam int AddrW = $clog2(HEAP_DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire mhku_pkg::cmd_type             req_command,
   input  wire logic [mhku_pkg::IDX_W-1:0]    req_index,
   input  wire logic [mhku_pkg::KEY_W-1:0]    req_key,
   input  wire logic [mhku_pkg::IDX_W-1:0]    heap_count,
   output logic                               wr_en,
   output logic      [AddrW-1:0]              wr_addr,
   output logic      [mhku_pkg::KEY_W-1:0]    wr_data,
   output logic      [AddrW-1:0]              rd_a_addr,
   output logic      [AddrW-1:0]              rd_b_addr,
   input  wire logic [mhku_pkg::KEY_W-1:0]    rd_a_data,
   input  wire logic [mhku_pkg::KEY_W-1:0]    rd_b_data,
   output logic                               res_valid,
   input  wire logic                          res_ready,
   output mhku_pkg::result_type               result
);
   import mhku_pkg::*;

   localparam int LastCap = (HEAP_DEPTH - 1 > 1023) ? 1023 : HEAP_DEPTH - 1;

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic                    rv_ff, rv_in;
   status_type              status_ff, status_in;
   logic [KEY_W-1:0]        rkey_ff, rkey_in;
   logic [IDX_W-1:0]        fidx_ff, fidx_in;

   logic [IDX_W-1:0]        last_slot;
   logic [IDX_W:0]          left_idx;
   logic [IDX_W:0]          right_idx;
   logic [IDX_W-1:0]        parent_idx;
   logic signed [KEY_W-1:0] rd_a_s;
   logic signed [KEY_W-1:0] rd_b_s;
   logic signed [KEY_W-1:0] cand_key;
   logic                    take_l;
   logic                    take_r;
   logic                    in_range;

   assign last_slot  = (heap_count < IDX_W'(LastCap)) ? heap_count : IDX_W'(LastCap);
   assign left_idx   = {pos_ff, 1'b0};
   assign right_idx  = {pos_ff, 1'b1};
   assign parent_idx = {1'b0, pos_ff[IDX_W-1:1]};
   assign rd_a_s     = $signed(rd_a_data);
   assign rd_b_s     = $signed(rd_b_data);
   assign in_range   = (req_index != '0) && (req_index <= last_slot);

   // smaller child, left wins a tie, key stays on a tie
   assign take_l   = rd_a_s < key_ff;
   assign cand_key = take_l ? rd_a_s : key_ff;
   assign take_r   = rv_ff && (rd_b_s < cand_key);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      pos_ff    <= pos_in;
      key_ff    <= key_in;
      rv_ff     <= rv_in;
      status_ff <= status_in;
      rkey_ff   <= rkey_in;
      fidx_ff   <= fidx_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      pos_in    = pos_ff;
      key_in    = key_ff;
      rv_in     = rv_ff;
      status_in = status_ff;
      rkey_in   = rkey_ff;
      fidx_in   = fidx_ff;
      wr_en     = 1'b0;
      wr_addr   = AddrW'(pos_ff);
      wr_data   = key_ff;
      rd_a_addr = AddrW'(pos_ff);
      rd_b_addr = AddrW'(right_idx);
      req_ready = 1'b0;
      res_valid = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            rd_a_addr = AddrW'(req_index);
            if (req_valid) begin
               cmd_in    = req_command;
               pos_in    = req_index;
               key_in    = $signed(req_key);
               rkey_in   = '0;
               status_in = STS_OK;
               fidx_in   = req_index;
               if (!in_range) begin
                  status_in = STS_RANGE;
                  fidx_in   = '0;
                  state_in  = S_FINISH;
               end else if (req_command == CMD_LOAD) begin
                  wr_en    = 1'b1;
                  wr_addr  = AddrW'(req_index);
                  wr_data  = req_key;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_LOOKUP;
               end
            end
         end

         S_LOOKUP: begin
            case (cmd_ff)
               CMD_READ: begin
                  rkey_in  = rd_a_data;
                  state_in = S_FINISH;
               end
               CMD_DEC: begin
                  if (key_ff >= rd_a_s) begin
                     status_in = STS_NOT_SMALLER;
                     state_in  = S_FINISH;
                  end else begin
                     state_in = S_UP_READ;
                  end
               end
               CMD_INC: begin
                  if (key_ff <= rd_a_s) begin
                     status_in = STS_NOT_LARGER;
                     state_in  = S_FINISH;
                  end else begin
                     state_in = S_DN_READ;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end

         // hole moves up: parent key drops into the hole until the key fits
         S_UP_READ: begin
            rd_a_addr = AddrW'(parent_idx);
            if (pos_ff == IDX_W'(1)) begin
               wr_en    = 1'b1;
               fidx_in  = pos_ff;
               state_in = S_FINISH;
            end else begin
               state_in = S_UP_CMP;
            end
         end

         S_UP_CMP: begin
            wr_en = 1'b1;
            if (key_ff < rd_a_s) begin
               wr_data  = rd_a_data;
               pos_in   = parent_idx;
               state_in = S_UP_READ;
            end else begin
               fidx_in  = pos_ff;
               state_in = S_FINISH;
            end
         end

         S_DN_READ: begin
            rd_a_addr = AddrW'(left_idx);
            rd_b_addr = AddrW'(right_idx);
            rv_in     = right_idx <= {1'b0, last_slot};
            if (left_idx > {1'b0, last_slot}) begin
               wr_en    = 1'b1;
               fidx_in  = pos_ff;
               state_in = S_FINISH;
            end else begin
               state_in = S_DN_CMP;
            end
         end

         S_DN_CMP: begin
            wr_en = 1'b1;
            if (take_r) begin
               wr_data  = rd_b_data;
               pos_in   = right_idx[IDX_W-1:0];
               state_in = S_DN_READ;
            end else if (take_l) begin
               wr_data  = rd_a_data;
               pos_in   = left_idx[IDX_W-1:0];
               state_in = S_DN_READ;
            end else begin
               fidx_in  = pos_ff;
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign result = '{status: status_ff, read_key: $signed(rkey_ff), final_index: fidx_ff};

endmodule

`default_nettype wire

### hw/rtl/min_heap_key_update.sv
// min-heap key update: load, read, decrease-key with sift up, increase-key with sift down
// load and out-of-range requests go straight to the result; a read or a rejected update
//   first looks the entry up; an accepted update then reads and compares one heap level at
//   a time until the key fits or the root or a leaf is reached
// one request in flight; the next is taken once the result sits in the output register
// reset clears heap_count, the output valid and the control state; the key store is not cleared
`default_nettype none

module min_heap_key_update #(
   parameter int HEAP_DEPTH = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [9:0]  csr_wr_data,   // heap_count
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,     // command[1:0], entry_index[11:2], new_key[43:12]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [47:0] rsp_tdata      // status[1:0], read_key[33:2], final_index[43:34]
);
   import mhku_pkg::*;

   localparam int AddrW = $clog2(HEAP_DEPTH);

   logic [IDX_W-1:0] heap_count_ff, heap_count_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   result_type       rsp_data_ff, rsp_data_in;

   logic             wr_en;
   logic [AddrW-1:0] wr_addr;
   logic [KEY_W-1:0] wr_data;
   logic [AddrW-1:0] rd_a_addr;
   logic [AddrW-1:0] rd_b_addr;
   logic [KEY_W-1:0] rd_a_data;
   logic [KEY_W-1:0] rd_b_data;
   logic             res_valid;
   logic             res_ready;
   result_type       result;

   assign heap_count_in = csr_wr_en ? csr_wr_data : heap_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_count_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         heap_count_ff <= heap_count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // output register frees up when empty or being drained
   assign res_ready     = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid_in = res_valid ? 1'b1 : (rsp_tvalid_ff && !rsp_tready);
   assign rsp_data_in   = (res_valid && res_ready) ? result : rsp_data_ff;

   mhku_ctrl #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_command (cmd_type'(req_tdata[1:0])),
      .req_index   (req_tdata[11:2]),
      .req_key     (req_tdata[43:12]),
      .heap_count  (heap_count_ff),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_a_addr   (rd_a_addr),
      .rd_b_addr   (rd_b_addr),
      .rd_a_data   (rd_a_data),
      .rd_b_data   (rd_b_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .result      (result)
   );

   mhku_store #(
      .HEAP_DEPTH (HEAP_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff.final_index, rsp_data_ff.read_key,
                        rsp_data_ff.status};

endmodule

`default_nettype wire
